>>> rtl/e2q_pkg.sv
package e2q_pkg;

  localparam int unsigned AtanEntries = 24;
  localparam int unsigned AngW = 16;
  localparam int unsigned PhW = 34;
  localparam int unsigned CW = 32;
  localparam int unsigned QW = 16;

  localparam logic signed [CW-1:0] InvGain = 32'sd652032874;

  localparam logic signed [PhW-1:0] AtanTable [AtanEntries] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
    34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
    34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
    34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
    34'sd652,       34'sd326,       34'sd163,       34'sd81
  };

  typedef struct packed {
    logic signed [AngW-1:0] roll;
    logic signed [AngW-1:0] pitch;
    logic signed [AngW-1:0] yaw;
  } angles_t;

  typedef struct packed {
    logic signed [CW-1:0]  x;
    logic signed [CW-1:0]  y;
    logic signed [PhW-1:0] z;
  } lane_t;

endpackage

>>> rtl/euler_to_quaternion.sv
// Channel | Handshake                  | Fields
// in      | in_valid_i / in_ready_o    | roll_angle_i, pitch_angle_i, yaw_angle_i
// out     | out_valid_o / out_ready_i  | quat_w_o, quat_x_o, quat_y_o, quat_z_o
//
// One request per cycle sustained while the output is not stalled; the CORDIC
// pipeline depth follows SINCOS_STEPS (capped at 24), one iteration per stage.
// rst_ni clears queue pointers and all valid bits; payload registers hold no reset.
// A stalled output freezes the back pipeline; the two-entry front queue keeps
// accepting until full, so in_ready_o drops only after two held requests.
module euler_to_quaternion #(
  parameter int unsigned SINCOS_STEPS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [e2q_pkg::AngW-1:0] roll_angle_i,
  input  logic signed [e2q_pkg::AngW-1:0] pitch_angle_i,
  input  logic signed [e2q_pkg::AngW-1:0] yaw_angle_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [e2q_pkg::QW-1:0] quat_w_o,
  output logic signed [e2q_pkg::QW-1:0] quat_x_o,
  output logic signed [e2q_pkg::QW-1:0] quat_y_o,
  output logic signed [e2q_pkg::QW-1:0] quat_z_o
);

  e2q_pkg::angles_t in_angles, q_angles;
  logic             q_valid, q_pop;

  // pack the request fields for the queue
  assign in_angles.roll  = roll_angle_i;
  assign in_angles.pitch = pitch_angle_i;
  assign in_angles.yaw   = yaw_angle_i;

  // front: hold up to two requests
  e2q_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_angles_i (in_angles),
    .q_valid_o   (q_valid),
    .q_pop_i     (q_pop),
    .q_angles_o  (q_angles)
  );

  // back: half-angle CORDIC, pair products, triple products, round and saturate
  e2q_back #(.SINCOS_STEPS(SINCOS_STEPS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_angles_i  (q_angles),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .quat_w_o    (quat_w_o),
    .quat_x_o    (quat_x_o),
    .quat_y_o    (quat_y_o),
    .quat_z_o    (quat_z_o)
  );

endmodule

>>> rtl/e2q_front.sv
module e2q_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  e2q_pkg::angles_t   in_angles_i,
  output logic               q_valid_o,
  input  logic               q_pop_i,
  output e2q_pkg::angles_t   q_angles_o
);

  e2q_pkg::angles_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_angles_o = mem_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_angles_i;
    end
  end

endmodule

>>> rtl/e2q_cordic_stage.sv
module e2q_cordic_stage #(
  parameter int unsigned Shift = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  e2q_pkg::lane_t [2:0]   lane_i,
  output logic                   valid_o,
  output e2q_pkg::lane_t [2:0]   lane_o
);

  e2q_pkg::lane_t [2:0] lane_d, lane_q;
  logic                 valid_q;
  logic signed [e2q_pkg::CW-1:0] dx [3];
  logic signed [e2q_pkg::CW-1:0] dy [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dx[k] = lane_i[k].y >>> Shift;
      dy[k] = lane_i[k].x >>> Shift;
      if (!lane_i[k].z[e2q_pkg::PhW-1]) begin
        lane_d[k].x = lane_i[k].x - dx[k];
        lane_d[k].y = lane_i[k].y + dy[k];
        lane_d[k].z = lane_i[k].z - e2q_pkg::AtanTable[Shift];
      end else begin
        lane_d[k].x = lane_i[k].x + dx[k];
        lane_d[k].y = lane_i[k].y - dy[k];
        lane_d[k].z = lane_i[k].z + e2q_pkg::AtanTable[Shift];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;

endmodule

>>> rtl/e2q_back.sv
module e2q_back #(
  parameter int unsigned SINCOS_STEPS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  output logic                          q_pop_o,
  input  e2q_pkg::angles_t              q_angles_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [e2q_pkg::QW-1:0] quat_w_o,
  output logic signed [e2q_pkg::QW-1:0] quat_x_o,
  output logic signed [e2q_pkg::QW-1:0] quat_y_o,
  output logic signed [e2q_pkg::QW-1:0] quat_z_o
);

  localparam int unsigned Steps =
    (SINCOS_STEPS > e2q_pkg::AtanEntries) ? e2q_pkg::AtanEntries : SINCOS_STEPS;
  localparam int unsigned CW = e2q_pkg::CW;
  localparam int unsigned PW = 2 * CW;
  localparam int unsigned SW = PW + 1;

  logic en;
  logic                 v [Steps+1];
  e2q_pkg::lane_t [2:0] ln [Steps+1];
  e2q_pkg::lane_t [2:0] init_q;
  logic                 init_v_q;

  // pair, triple and output stages
  logic                  v1_q, v2_q, out_v_q;
  logic signed [CW-1:0]  crcp_q, srsp_q, crsp_q, srcp_q, cy_q, sy_q;
  logic signed [PW-1:0]  t_q [8];
  logic signed [PW-1:0]  pr [4];
  logic signed [PW-1:0]  tp [8];
  logic signed [e2q_pkg::QW-1:0] q_d [4];
  logic signed [e2q_pkg::QW-1:0] q_q [4];

  function automatic logic signed [e2q_pkg::QW-1:0] to_q15(
    input logic signed [PW-1:0] a,
    input logic signed [PW-1:0] b,
    input logic                 sub
  );
    logic signed [SW-1:0] s;
    logic signed [SW-45-1:0] r;
    s = sub ? (SW'(a) - SW'(b)) : (SW'(a) + SW'(b));
    s = s + (SW'(1) <<< 44);
    r = s[SW-1:45];
    if (r > $signed((SW-45)'(32767))) begin
      return 16'sh7fff;
    end else if (r < -$signed((SW-45)'(32768))) begin
      return 16'sh8000;
    end
    return r[e2q_pkg::QW-1:0];
  endfunction

  assign en      = !out_v_q || out_ready_i;
  assign q_pop_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_v_q <= 1'b0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      out_v_q  <= 1'b0;
    end else if (en) begin
      init_v_q <= q_valid_i;
      v1_q     <= v[Steps];
      v2_q     <= v1_q;
      out_v_q  <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      init_q[0].z <= {{3{q_angles_i.roll[15]}},  q_angles_i.roll,  15'b0};
      init_q[1].z <= {{3{q_angles_i.pitch[15]}}, q_angles_i.pitch, 15'b0};
      init_q[2].z <= {{3{q_angles_i.yaw[15]}},   q_angles_i.yaw,   15'b0};
      for (int k = 0; k < 3; k++) begin
        init_q[k].x <= e2q_pkg::InvGain;
        init_q[k].y <= '0;
      end
    end
  end

  assign v[0]  = init_v_q;
  assign ln[0] = init_q;

  for (genvar g = 0; g < Steps; g++) begin : g_stage
    e2q_cordic_stage #(.Shift(g)) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v[g]),
      .lane_i  (ln[g]),
      .valid_o (v[g+1]),
      .lane_o  (ln[g+1])
    );
  end

  // lane 0 roll, 1 pitch, 2 yaw; x is cos, y is sin
  always_comb begin
    pr[0] = ln[Steps][0].x * ln[Steps][1].x + PW'(64'sd536870912);
    pr[1] = ln[Steps][0].y * ln[Steps][1].y + PW'(64'sd536870912);
    pr[2] = ln[Steps][0].x * ln[Steps][1].y + PW'(64'sd536870912);
    pr[3] = ln[Steps][0].y * ln[Steps][1].x + PW'(64'sd536870912);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      crcp_q <= pr[0][CW+29:30];
      srsp_q <= pr[1][CW+29:30];
      crsp_q <= pr[2][CW+29:30];
      srcp_q <= pr[3][CW+29:30];
      cy_q   <= ln[Steps][2].x;
      sy_q   <= ln[Steps][2].y;
    end
  end

  always_comb begin
    tp[0] = crcp_q * cy_q;
    tp[1] = srsp_q * sy_q;
    tp[2] = srcp_q * cy_q;
    tp[3] = crsp_q * sy_q;
    tp[4] = crsp_q * cy_q;
    tp[5] = srcp_q * sy_q;
    tp[6] = crcp_q * sy_q;
    tp[7] = srsp_q * cy_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 8; k++) begin
        t_q[k] <= tp[k];
      end
    end
  end

  always_comb begin
    q_d[0] = to_q15(t_q[0], t_q[1], 1'b0);
    q_d[1] = to_q15(t_q[2], t_q[3], 1'b1);
    q_d[2] = to_q15(t_q[4], t_q[5], 1'b0);
    q_d[3] = to_q15(t_q[6], t_q[7], 1'b1);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        q_q[k] <= q_d[k];
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign quat_w_o    = q_q[0];
  assign quat_x_o    = q_q[1];
  assign quat_y_o    = q_q[2];
  assign quat_z_o    = q_q[3];

endmodule

>>> rtl/e2q_checker.sv
module e2q_checker #(
  parameter int unsigned SINCOS_STEPS = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] quat_w_o,
  input logic [15:0] quat_x_o
);

  localparam int unsigned Cap =
    ((SINCOS_STEPS > e2q_pkg::AtanEntries) ? e2q_pkg::AtanEntries : SINCOS_STEPS) + 6;

  logic [7:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 8'd0;
    end else begin
      pend_q <= pend_q + {7'd0, in_acc} - {7'd0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(quat_w_o) && $stable(quat_x_o))
    else $error("stalled result changed");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 8'd0)
    else $error("result without request");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 8'(Cap))
    else $error("too many requests in flight");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 8'd0 |-> in_ready_o)
    else $error("not ready while empty");

endmodule

bind euler_to_quaternion e2q_checker #(.SINCOS_STEPS(SINCOS_STEPS)) u_e2q_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .quat_w_o    (quat_w_o),
  .quat_x_o    (quat_x_o)
);

>>> bench/euler_to_quaternion_tb.sv
module euler_to_quaternion_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Steps = 16;
  localparam int unsigned NumItems = 1150;
  localparam longint CycleLimit = 200000;

  typedef struct packed {
    logic signed [e2q_pkg::QW-1:0] w;
    logic signed [e2q_pkg::QW-1:0] x;
    logic signed [e2q_pkg::QW-1:0] y;
    logic signed [e2q_pkg::QW-1:0] z;
  } quat_t;

  // Floor shift on 64-bit signed values.
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  // Cosine and sine (Q.30) of half the binary angle, via rotation CORDIC.
  function automatic void half_angle_trig(logic signed [e2q_pkg::AngW-1:0] ang,
                                          output longint c, output longint s);
    longint ph;
    longint cx;
    longint sy;
    longint dx;
    longint dy;
    int n;
    ph = longint'(ang) * 32768;
    cx = longint'(e2q_pkg::InvGain);
    sy = 0;
    n = (Steps > e2q_pkg::AtanEntries) ? e2q_pkg::AtanEntries : Steps;
    for (int i = 0; i < n; i++) begin
      dx = floor_shr(sy, i);
      dy = floor_shr(cx, i);
      if (ph >= 0) begin
        cx -= dx;
        sy += dy;
        ph -= longint'(e2q_pkg::AtanTable[i]);
      end else begin
        cx += dx;
        sy -= dy;
        ph += longint'(e2q_pkg::AtanTable[i]);
      end
    end
    c = cx;
    s = sy;
  endfunction

  function automatic longint round_q30(longint a, longint b);
    return floor_shr(a * b + (longint'(1) <<< 29), 30);
  endfunction

  function automatic logic signed [e2q_pkg::QW-1:0] sat_q15(longint q60);
    longint r;
    r = floor_shr(q60 + (longint'(1) <<< 44), 45);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[e2q_pkg::QW-1:0];
  endfunction

  function automatic quat_t attitude_to_quat(e2q_pkg::angles_t a);
    longint cr, sr, cp, sp, cy, sy;
    longint crcp, srsp, crsp, srcp;
    quat_t q;
    half_angle_trig(a.roll, cr, sr);
    half_angle_trig(a.pitch, cp, sp);
    half_angle_trig(a.yaw, cy, sy);
    crcp = round_q30(cr, cp);
    srsp = round_q30(sr, sp);
    crsp = round_q30(cr, sp);
    srcp = round_q30(sr, cp);
    q.w = sat_q15(crcp * cy + srsp * sy);
    q.x = sat_q15(srcp * cy - crsp * sy);
    q.y = sat_q15(crsp * cy + srcp * sy);
    q.z = sat_q15(crcp * sy - srsp * cy);
    return q;
  endfunction

  // Tracks expected quaternions for accepted attitude requests.
  class quat_scoreboard;
    quat_t pending_q[$];
    int mismatches;

    function void note_request(e2q_pkg::angles_t a);
      pending_q.push_back(attitude_to_quat(a));
    endfunction

    function void check_quat(quat_t got);
      quat_t exp_q;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected quaternion %p", got);
        return;
      end
      exp_q = pending_q.pop_front();
      if (got !== exp_q) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"quaternion mismatch: exp w=%0d x=%0d y=%0d z=%0d",
                    " got w=%0d x=%0d y=%0d z=%0d"},
                   exp_q.w, exp_q.x, exp_q.y, exp_q.z, got.w, got.x, got.y, got.z);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [e2q_pkg::AngW-1:0] roll_angle_i = '0;
  logic signed [e2q_pkg::AngW-1:0] pitch_angle_i = '0;
  logic signed [e2q_pkg::AngW-1:0] yaw_angle_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [e2q_pkg::QW-1:0] quat_w_o, quat_x_o, quat_y_o, quat_z_o;

  quat_scoreboard sb = new();
  bit idle_off = 1'b0;
  int hold_off_cycles = 0;
  longint cycle_count = 0;

  always #4 clk_i = ~clk_i;

  euler_to_quaternion #(.SINCOS_STEPS(Steps)) dut (.*);

  // Count cycles and stop a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Sample handshakes at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      sb.note_request('{roll: roll_angle_i, pitch: pitch_angle_i, yaw: yaw_angle_i});
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_quat('{w: quat_w_o, x: quat_x_o, y: quat_y_o, z: quat_z_o});
  end

  // Receiver: random stall bursts, a long hold-off on request, none at the end.
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_ready_i <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!idle_off && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 4);
      end
    end
  end

  // Offer one request; hold valid and payload until accepted.
  task automatic send_request(logic [e2q_pkg::AngW-1:0] r, logic [e2q_pkg::AngW-1:0] p,
                              logic [e2q_pkg::AngW-1:0] y);
    int gap;
    if (!idle_off && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    roll_angle_i <= r;
    pitch_angle_i <= p;
    yaw_angle_i <= y;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  function automatic logic [e2q_pkg::AngW-1:0] pick_angle();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'h4000;
      4: return 16'hc000;
      default: return e2q_pkg::AngW'($urandom());
    endcase
  endfunction

  initial begin
    logic [e2q_pkg::AngW-1:0] corners [6];
    int wait_cycles;
    corners = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h4000, 16'hc000};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extremes, -pi on each axis, near-pi combinations.
    for (int i = 0; i < 6; i++)
      send_request(corners[i], corners[(i + 2) % 6], corners[(i + 4) % 6]);
    send_request(16'h8000, 16'h8000, 16'h8000);
    send_request(16'h7fff, 16'h7fff, 16'h7fff);
    send_request(16'h8000, 16'h0000, 16'h0000);
    send_request(16'h0000, 16'h8000, 16'h0000);
    send_request(16'h0000, 16'h0000, 16'h8000);
    send_request(16'h5555, 16'haaaa, 16'h1234);
    send_request(16'haaaa, 16'h5555, 16'hedcb);

    // Long receiver hold-off while requests keep coming.
    hold_off_cycles = 80;
    for (int i = 0; i < 60; i++) send_request(pick_angle(), pick_angle(), pick_angle());

    for (int i = 0; i < NumItems - 73; i++) begin
      if (i == NumItems - 250) idle_off = 1'b1;
      send_request(pick_angle(), pick_angle(), pick_angle());
    end
    in_valid_i <= 1'b0;

    wait_cycles = 0;
    while (sb.pending_q.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (40) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
